>>> rtl/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and constants for the CSV byte stream tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  localparam int FIELD_OUT_W = 16;
  localparam int ROW_OUT_W   = 32;

  localparam int TOKEN_QUEUE_DEPTH  = 2;
  localparam int RESULT_QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_QUOTE,
    CLS_COMMA,
    CLS_NEWLINE,
    CLS_END
  } byte_class_t;

  typedef enum logic [2:0] {
    EV_CONSUMED  = 3'd0,
    EV_DATA      = 3'd1,
    EV_FIELD_END = 3'd2,
    EV_ROW       = 3'd3,
    EV_EMPTY_ROW = 3'd4,
    EV_ERROR     = 3'd5
  } event_t;

  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  ch;
  } token_t;

  typedef struct packed {
    event_t                 kind;
    logic [7:0]             ch;
    logic [FIELD_OUT_W-1:0] field;
    logic [ROW_OUT_W-1:0]   row;
  } result_t;

  typedef struct packed {
    logic err;
    logic in_quotes;
  } back_status_t;

endpackage

>>> rtl/csvt_fifo.sv
// ----------------------------------------------------------------------------
// csvt_fifo
// Small register-based queue with head data shown while not empty.
// ----------------------------------------------------------------------------
module csvt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/csvt_front.sv
// ----------------------------------------------------------------------------
// csvt_front
// Classifies an incoming byte into a token for the parser.
// ----------------------------------------------------------------------------
module csvt_front (
  input  logic            [7:0] in_byte,
  input  logic                  end_of_input,
  output csvt_pkg::token_t      tok
);

  always_comb begin
    tok.ch = in_byte;
    if (end_of_input) begin
      tok.cls = csvt_pkg::CLS_END;
    end else begin
      case (in_byte)
        csvt_pkg::CH_QUOTE:   tok.cls = csvt_pkg::CLS_QUOTE;
        csvt_pkg::CH_COMMA:   tok.cls = csvt_pkg::CLS_COMMA;
        csvt_pkg::CH_NEWLINE: tok.cls = csvt_pkg::CLS_NEWLINE;
        default:              tok.cls = csvt_pkg::CLS_OTHER;
      endcase
    end
  end

endmodule

>>> rtl/csvt_back.sv
// ----------------------------------------------------------------------------
// csvt_back
// Parser state and event generation, one token per cycle while the result queue is not full.
// ----------------------------------------------------------------------------
module csvt_back #(
  parameter int FIELD_INDEX_BITS = 16,
  parameter int ROW_INDEX_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  csvt_pkg::token_t       tok,
  input  logic                   tok_valid,
  output logic                   tok_pop,
  output csvt_pkg::result_t      res,
  output logic                   res_push,
  input  logic                   res_full,
  output csvt_pkg::back_status_t sts
);

  logic                        inside_quotes;
  logic                        quote_pending;
  logic                        field_nonempty;
  logic [FIELD_INDEX_BITS-1:0] field_counter;
  logic [ROW_INDEX_BITS-1:0]   row_counter;
  logic                        error_latched;

  logic                        inside_quotes_next;
  logic                        quote_pending_next;
  logic                        field_nonempty_next;
  logic [FIELD_INDEX_BITS-1:0] field_counter_next;
  logic [ROW_INDEX_BITS-1:0]   row_counter_next;
  logic                        error_latched_next;

  logic [63:0]                 field_wide;
  logic [63:0]                 row_wide;
  logic                        row_empty;
  logic                        quoted_literal;
  csvt_pkg::event_t            ev;

  assign tok_pop  = tok_valid && !res_full;
  assign res_push = tok_pop;

  assign field_wide     = 64'(field_counter);
  assign row_wide       = 64'(row_counter);
  assign row_empty      = (field_counter == '0) && !field_nonempty;
  assign quoted_literal = inside_quotes && !quote_pending;

  always_comb begin
    inside_quotes_next  = inside_quotes;
    quote_pending_next  = quote_pending;
    field_nonempty_next = field_nonempty;
    field_counter_next  = field_counter;
    row_counter_next    = row_counter;
    error_latched_next  = error_latched;
    ev                  = csvt_pkg::EV_ERROR;
    if (!error_latched) begin
      case (tok.cls)
        csvt_pkg::CLS_END: begin
          ev = row_empty ? csvt_pkg::EV_EMPTY_ROW : csvt_pkg::EV_ROW;
          row_counter_next    = row_counter + 1'b1;
          field_counter_next  = '0;
          inside_quotes_next  = 1'b0;
          quote_pending_next  = 1'b0;
          field_nonempty_next = 1'b0;
        end
        csvt_pkg::CLS_QUOTE: begin
          if (inside_quotes) begin
            if (quote_pending) begin
              quote_pending_next  = 1'b0;
              field_nonempty_next = 1'b1;
              ev                  = csvt_pkg::EV_DATA;
            end else begin
              quote_pending_next = 1'b1;
              ev                 = csvt_pkg::EV_CONSUMED;
            end
          end else if (field_nonempty) begin
            ev = csvt_pkg::EV_DATA;
          end else begin
            inside_quotes_next = 1'b1;
            ev                 = csvt_pkg::EV_CONSUMED;
          end
        end
        csvt_pkg::CLS_NEWLINE: begin
          if (quoted_literal) begin
            field_nonempty_next = 1'b1;
            ev                  = csvt_pkg::EV_DATA;
          end else begin
            ev = row_empty ? csvt_pkg::EV_EMPTY_ROW : csvt_pkg::EV_ROW;
            row_counter_next    = row_counter + 1'b1;
            field_counter_next  = '0;
            inside_quotes_next  = 1'b0;
            quote_pending_next  = 1'b0;
            field_nonempty_next = 1'b0;
          end
        end
        csvt_pkg::CLS_COMMA: begin
          if (quoted_literal) begin
            field_nonempty_next = 1'b1;
            ev                  = csvt_pkg::EV_DATA;
          end else begin
            if (field_counter != '1) begin
              field_counter_next = field_counter + 1'b1;
            end
            inside_quotes_next  = 1'b0;
            quote_pending_next  = 1'b0;
            field_nonempty_next = 1'b0;
            ev                  = csvt_pkg::EV_FIELD_END;
          end
        end
        default: begin
          if (inside_quotes && quote_pending) begin
            error_latched_next = 1'b1;
            ev                 = csvt_pkg::EV_ERROR;
          end else begin
            field_nonempty_next = 1'b1;
            ev                  = csvt_pkg::EV_DATA;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.kind  = ev;
    res.ch    = (ev == csvt_pkg::EV_DATA) ? tok.ch : 8'h00;
    res.field = field_wide[csvt_pkg::FIELD_OUT_W-1:0];
    res.row   = row_wide[csvt_pkg::ROW_OUT_W-1:0];
  end

  assign sts.err       = error_latched;
  assign sts.in_quotes = inside_quotes;

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes  <= 1'b0;
      quote_pending  <= 1'b0;
      field_nonempty <= 1'b0;
      field_counter  <= '0;
      row_counter    <= '0;
      error_latched  <= 1'b0;
    end else if (tok_pop) begin
      inside_quotes  <= inside_quotes_next;
      quote_pending  <= quote_pending_next;
      field_nonempty <= field_nonempty_next;
      field_counter  <= field_counter_next;
      row_counter    <= row_counter_next;
      error_latched  <= error_latched_next;
    end
  end

endmodule

>>> rtl/csv_byte_stream_tokenizer_core.sv
// ----------------------------------------------------------------------------
// csv_byte_stream_tokenizer_core
// CSV tokenizer with quoting per RFC 4180: one byte (or an end-of-input mark)
// goes in per transfer and exactly one event comes out for it, in order. The
// block sustains one transfer per cycle on both sides while the output is
// popped every cycle. The token queue behind the classifier captures the byte
// at the transfer edge; the result queue behind the parser registers its event
// once the parser takes the token, which waits while that queue is full.
// Each event carries the field index and row number as they stood before that
// byte. A byte other than a quote, comma or newline after a closing quote
// raises a format error that repeats for every later byte until reset.
// ----------------------------------------------------------------------------
module csv_byte_stream_tokenizer_core #(
  parameter int FIELD_INDEX_BITS = 16,
  parameter int ROW_INDEX_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] field_number,
  output logic [31:0] row_index
);

  localparam int TOK_W = $bits(csvt_pkg::token_t);
  localparam int RES_W = $bits(csvt_pkg::result_t);

  csvt_pkg::token_t       front_tok;
  csvt_pkg::token_t       head_tok;
  logic [TOK_W-1:0]       tok_dout;
  logic                   tok_empty;
  logic                   tok_pop;
  csvt_pkg::result_t      back_res;
  csvt_pkg::result_t      head_res;
  logic [RES_W-1:0]       res_dout;
  logic                   res_push;
  logic                   res_full;
  csvt_pkg::back_status_t sts;

  csvt_front u_front (
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .tok          (front_tok)
  );

  csvt_fifo #(
    .WIDTH (TOK_W),
    .DEPTH (csvt_pkg::TOKEN_QUEUE_DEPTH)
  ) u_tok_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_tok),
    .full  (full),
    .pop   (tok_pop),
    .dout  (tok_dout),
    .empty (tok_empty)
  );

  assign head_tok = tok_dout;

  csvt_back #(
    .FIELD_INDEX_BITS (FIELD_INDEX_BITS),
    .ROW_INDEX_BITS   (ROW_INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (head_tok),
    .tok_valid (!tok_empty),
    .tok_pop   (tok_pop),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (res_full),
    .sts       (sts)
  );

  csvt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (csvt_pkg::RESULT_QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign head_res     = res_dout;
  assign event_kind   = head_res.kind;
  assign out_byte     = head_res.ch;
  assign field_number = head_res.field;
  assign row_index    = head_res.row;

  a_err_sticky : assert property (@(posedge clk) disable iff (rst)
    sts.err |=> sts.err)
    else $error("error flag cleared without reset");

  a_no_res_overflow : assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  a_tok_lands : assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !tok_empty)
    else $error("accepted byte missing from token queue");

  a_err_reported : assert property (@(posedge clk) disable iff (rst)
    (sts.err && res_push) |-> (back_res.kind == csvt_pkg::EV_ERROR))
    else $error("event other than error while error latched");

endmodule

>>> tb/sv/csv_byte_stream_tokenizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_byte_stream_tokenizer_core_tb
// Self-checking bench for the CSV tokenizer. Byte and end-of-input items are
// pushed with random gaps and results are popped with random stalls. A
// tokenizer model runs on every accepted byte and each popped event is
// compared field by field against it. The stimulus has a short directed
// sequence, then random well-formed rows mixed with truncated ones, then a
// run of commas that walks the field index up, and last a format error.
// ----------------------------------------------------------------------------
module csv_byte_stream_tokenizer_core_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RUN_COMMAS     = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       hold;
  } stim_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        end_of_input;
  logic        empty;
  logic        pop;
  logic [2:0]  event_kind;
  logic [7:0]  out_byte;
  logic [15:0] field_number;
  logic [31:0] row_index;

  stim_t             pending_bytes[$];
  csvt_pkg::result_t expected_events[$];
  logic              hold_next;
  int                error_count;
  int                cycle_count;
  int                quiet_cycles;
  int                random_items;

  // tokenizer model state
  logic                             in_quotes;
  logic                             quote_seen;
  logic                             field_has_data;
  logic [csvt_pkg::FIELD_OUT_W-1:0] field_idx;
  logic [csvt_pkg::ROW_OUT_W-1:0]   row_num;
  logic                             format_err;

  csv_byte_stream_tokenizer_core u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .empty        (empty),
    .pop          (pop),
    .event_kind   (event_kind),
    .out_byte     (out_byte),
    .field_number (field_number),
    .row_index    (row_index)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic csvt_pkg::event_t close_row();
    csvt_pkg::event_t ev;
    ev = (field_idx == '0 && !field_has_data) ? csvt_pkg::EV_EMPTY_ROW : csvt_pkg::EV_ROW;
    row_num        = row_num + 1'b1;
    field_idx      = '0;
    in_quotes      = 1'b0;
    quote_seen     = 1'b0;
    field_has_data = 1'b0;
    return ev;
  endfunction

  task automatic tokenize_step(input logic [7:0] b, input logic eoi);
    csvt_pkg::result_t r;
    r.kind  = csvt_pkg::EV_CONSUMED;
    r.ch    = 8'h00;
    r.field = field_idx;
    r.row   = row_num;
    if (format_err) begin
      r.kind = csvt_pkg::EV_ERROR;
    end else if (eoi) begin
      r.kind = close_row();
    end else if (b == csvt_pkg::CH_QUOTE) begin
      if (in_quotes) begin
        if (quote_seen) begin
          quote_seen     = 1'b0;
          field_has_data = 1'b1;
          r.kind         = csvt_pkg::EV_DATA;
          r.ch           = b;
        end else begin
          quote_seen = 1'b1;
        end
      end else if (field_has_data) begin
        r.kind = csvt_pkg::EV_DATA;
        r.ch   = b;
      end else begin
        in_quotes = 1'b1;
      end
    end else if ((b == csvt_pkg::CH_NEWLINE || b == csvt_pkg::CH_COMMA) &&
                 in_quotes && !quote_seen) begin
      field_has_data = 1'b1;
      r.kind         = csvt_pkg::EV_DATA;
      r.ch           = b;
    end else if (b == csvt_pkg::CH_NEWLINE) begin
      r.kind = close_row();
    end else if (b == csvt_pkg::CH_COMMA) begin
      if (field_idx != '1) field_idx = field_idx + 1'b1;
      in_quotes      = 1'b0;
      quote_seen     = 1'b0;
      field_has_data = 1'b0;
      r.kind         = csvt_pkg::EV_FIELD_END;
    end else if (in_quotes && quote_seen) begin
      format_err = 1'b1;
      r.kind     = csvt_pkg::EV_ERROR;
    end else begin
      field_has_data = 1'b1;
      r.kind         = csvt_pkg::EV_DATA;
      r.ch           = b;
    end
    expected_events.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // stimulus builders
  task automatic add_item(input logic [7:0] b, input logic eoi);
    stim_t s;
    s.ch   = b;
    s.eoi  = eoi;
    s.hold = hold_next;
    hold_next = 1'b0;
    pending_bytes.push_back(s);
    random_items++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_item(b, 1'b0);
  endtask

  task automatic add_eoi();
    add_item(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] plain_byte(input logic allow_quote);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == csvt_pkg::CH_COMMA || b == csvt_pkg::CH_NEWLINE ||
               (!allow_quote && b == csvt_pkg::CH_QUOTE));
    return b;
  endfunction

  task automatic add_field();
    int kind;
    int n;
    int sel;
    kind = $urandom_range(9);
    if (kind >= 2 && kind <= 5) begin
      n = $urandom_range(1, 6);
      add_byte(plain_byte(1'b0));
      for (int i = 1; i < n; i++) begin
        if ($urandom_range(99) < 15) add_byte(csvt_pkg::CH_QUOTE);
        else add_byte(plain_byte(1'b1));
      end
    end else if (kind >= 6) begin
      n = $urandom_range(0, 6);
      add_byte(csvt_pkg::CH_QUOTE);
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(99);
        if (sel < 15) begin
          add_byte(csvt_pkg::CH_QUOTE);
          add_byte(csvt_pkg::CH_QUOTE);
        end else if (sel < 25) begin
          add_byte(csvt_pkg::CH_COMMA);
        end else if (sel < 35) begin
          add_byte(csvt_pkg::CH_NEWLINE);
        end else begin
          add_byte(plain_byte(1'b0));
        end
      end
      add_byte(csvt_pkg::CH_QUOTE);
    end
  endtask

  task automatic add_row();
    int sel;
    int nf;
    sel = $urandom_range(99);
    if (sel < 8) begin
      add_byte(csvt_pkg::CH_NEWLINE);
    end else if (sel < 11) begin
      add_eoi();
    end else if (sel < 16) begin
      // truncated row: open quote or open field cut by end of input
      if ($urandom_range(1)) add_byte(csvt_pkg::CH_QUOTE);
      nf = $urandom_range(0, 3);
      for (int i = 0; i < nf; i++) add_byte(plain_byte(1'b0));
      add_eoi();
    end else begin
      nf = $urandom_range(1, 5);
      for (int i = 0; i < nf; i++) begin
        if (i != 0) add_byte(csvt_pkg::CH_COMMA);
        add_field();
      end
      if ($urandom_range(99) < 88) add_byte(csvt_pkg::CH_NEWLINE);
      else add_eoi();
    end
  endtask

  // driver
  always @(negedge clk) begin : drive_inputs
    logic calm;
    calm = (cycle_count >= 400 && cycle_count < 1400);
    if (rst) begin
      push <= 1'b0;
      pop  <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99) >= 35);
      if (pending_bytes.size() != 0 && pending_bytes[0].hold && expected_events.size() == 0)
        pending_bytes[0].hold = 1'b0;
      if (pending_bytes.size() != 0 && !pending_bytes[0].hold &&
          (calm || $urandom_range(99) >= 35)) begin
        push         <= 1'b1;
        in_byte      <= pending_bytes[0].ch;
        end_of_input <= pending_bytes[0].eoi;
      end else begin
        push         <= 1'b0;
        in_byte      <= 8'($urandom_range(255));
        end_of_input <= 1'($urandom_range(1));
      end
    end
  end

  // monitor, model update and watchdog
  always @(posedge clk) begin : watch_outputs
    csvt_pkg::result_t want;
    logic              moved;
    cycle_count++;
    moved = 1'b0;
    if (!rst) begin
      if (!empty && pop) begin
        moved = 1'b1;
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected result", 32'(event_kind), 32'h0);
        end else begin
          want = expected_events.pop_front();
          if (event_kind !== want.kind)
            report_mismatch("event_kind", 32'(event_kind), 32'(want.kind));
          if (out_byte !== want.ch)
            report_mismatch("out_byte", 32'(out_byte), 32'(want.ch));
          if (field_number !== want.field)
            report_mismatch("field_number", 32'(field_number), 32'(want.field));
          if (row_index !== want.row)
            report_mismatch("row_index", row_index, want.row);
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        void'(pending_bytes.pop_front());
        tokenize_step(in_byte, end_of_input);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    push           = 1'b0;
    pop            = 1'b0;
    in_byte        = 8'h00;
    end_of_input   = 1'b0;
    hold_next      = 1'b0;
    error_count    = 0;
    cycle_count    = 0;
    quiet_cycles   = 0;
    random_items   = 0;
    in_quotes      = 1'b0;
    quote_seen     = 1'b0;
    field_has_data = 1'b0;
    field_idx      = '0;
    row_num        = '0;
    format_err     = 1'b0;

    // directed: byte extremes, quoting rules, empty rows, end of input
    add_byte(8'h00); add_byte(8'hFF); add_byte(csvt_pkg::CH_COMMA);
    add_byte(csvt_pkg::CH_QUOTE); add_byte("a"); add_byte(csvt_pkg::CH_QUOTE);
    add_byte(csvt_pkg::CH_QUOTE);
    add_byte(csvt_pkg::CH_COMMA); add_byte(csvt_pkg::CH_NEWLINE);
    add_byte(csvt_pkg::CH_QUOTE); add_byte(csvt_pkg::CH_COMMA);
    add_byte("b"); add_byte(csvt_pkg::CH_QUOTE); add_byte("c");
    add_byte(csvt_pkg::CH_NEWLINE);
    add_byte(csvt_pkg::CH_NEWLINE);
    add_byte(csvt_pkg::CH_QUOTE); add_byte(csvt_pkg::CH_QUOTE);
    add_byte(csvt_pkg::CH_NEWLINE);
    add_byte("x"); add_item(8'hFF, 1'b1);
    add_eoi();
    add_byte(csvt_pkg::CH_QUOTE); add_byte("z"); add_eoi();

    // random rows
    hold_next    = 1'b1;
    random_items = 0;
    while (random_items < 880) add_row();

    // long row of empty fields
    hold_next = 1'b1;
    for (int i = 0; i < RUN_COMMAS; i++) add_byte(csvt_pkg::CH_COMMA);
    add_byte("z");
    add_byte(csvt_pkg::CH_NEWLINE);

    // closing quote followed by a plain byte, then sticky error
    hold_next = 1'b1;
    add_byte(csvt_pkg::CH_QUOTE); add_byte("q"); add_byte(csvt_pkg::CH_QUOTE);
    add_byte("r");
    add_byte("a"); add_eoi(); add_byte(csvt_pkg::CH_COMMA);
    add_byte(csvt_pkg::CH_NEWLINE);
    add_byte(csvt_pkg::CH_QUOTE);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || expected_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/csvt_pkg.sv
rtl/csvt_fifo.sv
rtl/csvt_front.sv
rtl/csvt_back.sv
rtl/csv_byte_stream_tokenizer_core.sv
tb/sv/csv_byte_stream_tokenizer_core_tb.sv
